### rtl/dnsx_pkg.sv
// ----------------------------------------------------------------------------
// dnsx_pkg
// Shared constants and types for the DNS answer IPv4 extractor.
// ----------------------------------------------------------------------------
package dnsx_pkg;

    // Bytes parsed per message; later bytes only end the message
    localparam int MAX_BYTES = 512;
    localparam int POS_W     = $clog2(MAX_BYTES + 1);

    // Header layout
    localparam int HDR_LEN        = 12;
    localparam int HDR_RCODE_IDX  = 3;
    localparam int HDR_QD_HI_IDX  = 4;
    localparam int HDR_QD_LO_IDX  = 5;
    localparam int HDR_AN_HI_IDX  = 6;
    localparam int HDR_AN_LO_IDX  = 7;
    localparam int HDR_LAST_IDX   = 11;

    // Record layout
    localparam logic [7:0]  NAME_PTR_MASK = 8'hC0;
    localparam logic [3:0]  QFIXED_LEN    = 4'd4;
    localparam logic [3:0]  AFIXED_LEN    = 4'd10;
    localparam logic [3:0]  AF_TYPE_HI    = 4'd0;
    localparam logic [3:0]  AF_TYPE_LO    = 4'd1;
    localparam logic [3:0]  AF_LEN_HI     = 4'd8;
    localparam logic [3:0]  AF_LEN_LO     = 4'd9;
    localparam logic [3:0]  ADDR_LEN      = 4'd4;
    localparam logic [15:0] TYPE_A        = 16'd1;
    localparam logic [15:0] TYPE_A_LEN    = 16'd4;

    // Result status codes
    localparam logic [1:0] ST_FOUND      = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_NO_RECORD  = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [31:0] address;
    } dnsx_result_t;

endpackage

### rtl/dnsx_in_if.sv
// ----------------------------------------------------------------------------
// dnsx_in_if
// Byte stream channel: one message byte per word, flag on the last byte.
// ----------------------------------------------------------------------------
interface dnsx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/dnsx_out_if.sv
// ----------------------------------------------------------------------------
// dnsx_out_if
// Result channel: one status and IPv4 address word per message.
// ----------------------------------------------------------------------------
interface dnsx_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] address;

    modport source (output valid, output status, output address, input ready);
    modport sink   (input valid, input status, input address, output ready);
endinterface

### rtl/dnsx_core.sv
// ----------------------------------------------------------------------------
// dnsx_core
// Per-byte DNS response parser: holds the walk state through header,
// questions and answers and flags the result of each message.
// ----------------------------------------------------------------------------
module dnsx_core
    import dnsx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output dnsx_result_t result
);

    localparam logic [3:0] PH_HEADER = 4'd0;
    localparam logic [3:0] PH_QNAME  = 4'd1;
    localparam logic [3:0] PH_QLABEL = 4'd2;
    localparam logic [3:0] PH_QPTR   = 4'd3;
    localparam logic [3:0] PH_QFIXED = 4'd4;
    localparam logic [3:0] PH_ANAME  = 4'd5;
    localparam logic [3:0] PH_ALABEL = 4'd6;
    localparam logic [3:0] PH_APTR   = 4'd7;
    localparam logic [3:0] PH_AFIXED = 4'd8;
    localparam logic [3:0] PH_ADATA  = 4'd9;
    localparam logic [3:0] PH_AADDR  = 4'd10;
    localparam logic [3:0] PH_BADHDR = 4'd11;
    localparam logic [3:0] PH_NOMORE = 4'd12;
    localparam logic [3:0] PH_DONE   = 4'd13;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BYTES);

    logic [3:0]       phase_reg,      phase_next;
    logic [POS_W-1:0] position_reg,   position_next;
    logic [3:0]       field_cnt_reg,  field_cnt_next;
    logic [15:0]      skip_left_reg,  skip_left_next;
    logic [15:0]      q_left_reg,     q_left_next;
    logic [15:0]      a_left_reg,     a_left_next;
    logic [3:0]       rcode_reg,      rcode_next;
    logic [15:0]      rec_type_reg,   rec_type_next;
    logic [15:0]      rec_len_reg,    rec_len_next;
    logic [31:0]      addr_reg,       addr_next;

    logic [3:0] field_inc;
    logic       is_answer;
    logic       hit;
    logic       bad;

    // Walk one byte through the message layout
    always_comb
    begin
        phase_next     = phase_reg;
        position_next  = position_reg;
        field_cnt_next = field_cnt_reg;
        skip_left_next = skip_left_reg;
        q_left_next    = q_left_reg;
        a_left_next    = a_left_reg;
        rcode_next     = rcode_reg;
        rec_type_next  = rec_type_reg;
        rec_len_next   = rec_len_reg;
        addr_next      = addr_reg;
        field_inc      = field_cnt_reg + 4'd1;
        is_answer      = (phase_reg == PH_ANAME) || (phase_reg == PH_ALABEL)
                         || (phase_reg == PH_APTR);
        hit            = 1'b0;
        bad            = 1'b0;
        result         = '0;

        if (fire && (position_reg < POS_MAX))
        begin
            position_next = position_reg + POS_W'(1);
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (position_reg == POS_W'(HDR_RCODE_IDX))
                        rcode_next = data_byte[3:0];
                    else if (position_reg == POS_W'(HDR_QD_HI_IDX))
                        q_left_next = {data_byte, 8'h00};
                    else if (position_reg == POS_W'(HDR_QD_LO_IDX))
                        q_left_next = {q_left_reg[15:8], data_byte};
                    else if (position_reg == POS_W'(HDR_AN_HI_IDX))
                        a_left_next = {data_byte, 8'h00};
                    else if (position_reg == POS_W'(HDR_AN_LO_IDX))
                        a_left_next = {a_left_reg[15:8], data_byte};
                    else if (position_reg == POS_W'(HDR_LAST_IDX))
                    begin
                        priority if (a_left_reg == 16'd0 || rcode_reg != 4'd0)
                            phase_next = PH_BADHDR;
                        else if (q_left_reg == 16'd0)
                            phase_next = PH_ANAME;
                        else
                            phase_next = PH_QNAME;
                    end
                end
                PH_QNAME, PH_ANAME:
                begin
                    // Pointer, root label or label length
                    priority if ((data_byte & NAME_PTR_MASK) == NAME_PTR_MASK)
                        phase_next = is_answer ? PH_APTR : PH_QPTR;
                    else if (data_byte == 8'd0)
                    begin
                        field_cnt_next = 4'd0;
                        phase_next     = is_answer ? PH_AFIXED : PH_QFIXED;
                    end
                    else
                    begin
                        skip_left_next = {8'h00, data_byte};
                        phase_next     = is_answer ? PH_ALABEL : PH_QLABEL;
                    end
                end
                PH_QLABEL, PH_ALABEL:
                begin
                    skip_left_next = skip_left_reg - 16'd1;
                    if (skip_left_reg == 16'd1)
                        phase_next = is_answer ? PH_ANAME : PH_QNAME;
                end
                PH_QPTR, PH_APTR:
                begin
                    field_cnt_next = 4'd0;
                    phase_next     = is_answer ? PH_AFIXED : PH_QFIXED;
                end
                PH_QFIXED:
                begin
                    field_cnt_next = field_inc;
                    if (field_inc >= QFIXED_LEN)
                    begin
                        field_cnt_next = 4'd0;
                        q_left_next    = q_left_reg - 16'd1;
                        phase_next     = (q_left_reg == 16'd1) ? PH_ANAME : PH_QNAME;
                    end
                end
                PH_AFIXED:
                begin
                    // Capture type and data length from the fixed part
                    if (field_cnt_reg == AF_TYPE_HI)
                        rec_type_next = {data_byte, 8'h00};
                    if (field_cnt_reg == AF_TYPE_LO)
                        rec_type_next = {rec_type_reg[15:8], data_byte};
                    if (field_cnt_reg == AF_LEN_HI)
                        rec_len_next = {data_byte, 8'h00};
                    if (field_cnt_reg == AF_LEN_LO)
                        rec_len_next = {rec_len_reg[15:8], data_byte};
                    field_cnt_next = field_inc;
                    if (field_inc >= AFIXED_LEN)
                    begin
                        field_cnt_next = 4'd0;
                        priority if (rec_type_next == TYPE_A && rec_len_next == TYPE_A_LEN)
                        begin
                            addr_next  = 32'd0;
                            phase_next = PH_AADDR;
                        end
                        else if (rec_len_next == 16'd0)
                        begin
                            a_left_next = a_left_reg - 16'd1;
                            phase_next  = (a_left_reg == 16'd1) ? PH_NOMORE : PH_ANAME;
                        end
                        else
                        begin
                            skip_left_next = rec_len_next;
                            phase_next     = PH_ADATA;
                        end
                    end
                end
                PH_ADATA:
                begin
                    skip_left_next = skip_left_reg - 16'd1;
                    if (skip_left_reg == 16'd1)
                    begin
                        a_left_next = a_left_reg - 16'd1;
                        phase_next  = (a_left_reg == 16'd1) ? PH_NOMORE : PH_ANAME;
                    end
                end
                PH_AADDR:
                begin
                    addr_next      = {addr_reg[23:0], data_byte};
                    field_cnt_next = field_inc;
                    if (field_inc >= ADDR_LEN)
                    begin
                        field_cnt_next = 4'd0;
                        hit            = 1'b1;
                        phase_next     = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Report the address, or a failure on the last byte
        bad = (phase_next == PH_HEADER) || (phase_next == PH_BADHDR)
              || (position_next <= POS_W'(HDR_LEN));
        if (hit)
        begin
            result.valid   = 1'b1;
            result.status  = ST_FOUND;
            result.address = addr_next;
        end
        else if (fire && last_byte && (phase_reg != PH_DONE))
        begin
            result.valid   = 1'b1;
            result.status  = bad ? ST_BAD_HEADER : ST_NO_RECORD;
            result.address = 32'd0;
        end

        // Drop all message state after the last byte
        if (fire && last_byte)
        begin
            phase_next     = PH_HEADER;
            position_next  = '0;
            field_cnt_next = 4'd0;
            skip_left_next = 16'd0;
            q_left_next    = 16'd0;
            a_left_next    = 16'd0;
            rcode_next     = 4'd0;
            rec_type_next  = 16'd0;
            rec_len_next   = 16'd0;
            addr_next      = 32'd0;
        end
    end

    // Hold walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            position_reg  <= '0;
            field_cnt_reg <= 4'd0;
            skip_left_reg <= 16'd0;
            q_left_reg    <= 16'd0;
            a_left_reg    <= 16'd0;
            rcode_reg     <= 4'd0;
            rec_type_reg  <= 16'd0;
            rec_len_reg   <= 16'd0;
            addr_reg      <= 32'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            position_reg  <= position_next;
            field_cnt_reg <= field_cnt_next;
            skip_left_reg <= skip_left_next;
            q_left_reg    <= q_left_next;
            a_left_reg    <= a_left_next;
            rcode_reg     <= rcode_next;
            rec_type_reg  <= rec_type_next;
            rec_len_reg   <= rec_len_next;
            addr_reg      <= addr_next;
        end
    end

endmodule

### rtl/dns_answer_ipv4_extractor.sv
// A result word appears on res in the cycle after the byte that completes it.
// Throughput: one byte per cycle unless input is stalled; the parser state updates on every accepted byte.
// A pending result word does not stall input unless res is held off and full.
// Reset (rst_n, asynchronous, active low) returns the parser to the header and
// empties the result register.
// ----------------------------------------------------------------------------
// dns_answer_ipv4_extractor
// Extracts the first IPv4 A record from a DNS response byte stream and
// delivers one status and address word per message.
// ----------------------------------------------------------------------------
module dns_answer_ipv4_extractor
    import dnsx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    dnsx_in_if.sink msg,
    dnsx_out_if.source res
);

    dnsx_result_t core_result;
    logic         fire;
    logic         res_valid_reg;
    logic [1:0]   res_status_reg;
    logic [31:0]  res_addr_reg;

    // Take a byte whenever the result register is free or draining
    assign msg.ready = !res_valid_reg || res.ready;
    assign fire      = msg.valid && msg.ready;

    dnsx_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (msg.data_byte),
        .last_byte (msg.last_byte),
        .result    (core_result)
    );

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (core_result.valid)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (core_result.valid)
        begin
            res_status_reg <= core_result.status;
            res_addr_reg   <= core_result.address;
        end
    end

    assign res.valid   = res_valid_reg;
    assign res.status  = res_status_reg;
    assign res.address = res_addr_reg;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DNS answer IPv4 extractor. Feeds whole DNS
// response messages byte by byte, mostly well-formed with random content plus
// truncated, padded, overlong and noise messages. Every status/address word
// is checked against an in-bench model of the parser.
// ----------------------------------------------------------------------------
module tb;
    import dnsx_pkg::*;

    localparam int RANDOM_BYTES = 2000;
    localparam int MIN_MESSAGES = 40;
    localparam int BURST_FIRST  = 4;
    localparam int BURST_END    = 30;
    localparam int PAUSE_MSG    = 35;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DIR_ROWS     = 28;

    typedef enum logic [3:0] {
        S_HEADER, S_QNAME, S_QLABEL, S_QPTR, S_QFIXED,
        S_ANAME, S_ALABEL, S_APTR, S_AFIXED, S_ADATA,
        S_AADDR, S_BADHDR, S_NOMORE, S_DONE
    } parse_stage_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] address;
    } answer_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        pinned;
        logic [1:0]  status;
        logic [31:0] address;
    } dir_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dnsx_in_if  msg_if ();
    dnsx_out_if res_if ();

    dns_answer_ipv4_extractor i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .res   (res_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Parser model state
    parse_stage_t stage;
    int unsigned  byte_pos;
    logic [3:0]   field_cnt;
    logic [15:0]  skip_cnt;
    logic [15:0]  qd_left;
    logic [15:0]  an_left;
    logic [3:0]   rcode;
    logic [15:0]  rr_type;
    logic [15:0]  rr_len;
    logic [31:0]  addr_acc;
    bit           reported;

    answer_t     pending_answers [$];
    logic [7:0]  msg_bytes [$];
    int          mismatches = 0;
    int unsigned cycle_cnt  = 0;
    bit          burst_on   = 1'b0;
    bit          hold_req   = 1'b0;
    bit          hold_done  = 1'b0;
    bit          src_quiet  = 1'b0;
    bit          snk_quiet  = 1'b0;

    // Directed messages: a lone byte, then one A record answer ending on its data
    dir_row_t dir_tbl [DIR_ROWS] = '{
        '{8'hFF, 1'b1, 1'b1, ST_BAD_HEADER, 32'h0000_0000},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h81, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h80, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h01, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h01, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h01, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h0E, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h10, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h04, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'hFF, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h00, 1'b0, 1'b0, ST_FOUND, 32'h0},
        '{8'h01, 1'b1, 1'b1, ST_FOUND, 32'hFF00_0001}
    };

    task automatic clear_parser();
        stage     = S_HEADER;
        byte_pos  = 0;
        field_cnt = '0;
        skip_cnt  = '0;
        qd_left   = '0;
        an_left   = '0;
        rcode     = '0;
        rr_type   = '0;
        rr_len    = '0;
        addr_acc  = '0;
        reported  = 1'b0;
    endtask

    task automatic close_answer();
        an_left = an_left - 16'd1;
        stage   = (an_left == 16'd0) ? S_NOMORE : S_ANAME;
    endtask

    // Start of a name: pointer, root label or label length
    task automatic take_name(input logic [7:0] b, input bit is_answer);
        if ((b & NAME_PTR_MASK) == NAME_PTR_MASK)
        begin
            stage = is_answer ? S_APTR : S_QPTR;
        end
        else if (b == 8'h00)
        begin
            field_cnt = '0;
            stage     = is_answer ? S_AFIXED : S_QFIXED;
        end
        else
        begin
            skip_cnt = {8'h00, b};
            stage    = is_answer ? S_ALABEL : S_QLABEL;
        end
    endtask

    // Advance the parser model by one byte and report the word it yields
    task automatic predict_byte(input logic [7:0] b, input logic last,
                                output bit got, output answer_t ans);
        int unsigned idx;
        bit          found;

        got   = 1'b0;
        found = 1'b0;
        ans   = '0;
        if (byte_pos < MAX_BYTES)
        begin
            idx      = byte_pos;
            byte_pos = byte_pos + 1;
            if (!reported)
            begin
                case (stage)
                    S_HEADER:
                    begin
                        if (idx == HDR_RCODE_IDX) rcode = b[3:0];
                        else if (idx == HDR_QD_HI_IDX) qd_left = {b, 8'h00};
                        else if (idx == HDR_QD_LO_IDX) qd_left[7:0] = b;
                        else if (idx == HDR_AN_HI_IDX) an_left = {b, 8'h00};
                        else if (idx == HDR_AN_LO_IDX) an_left[7:0] = b;
                        else if (idx == HDR_LAST_IDX)
                        begin
                            if (an_left == 16'd0 || rcode != 4'd0) stage = S_BADHDR;
                            else if (qd_left == 16'd0) stage = S_ANAME;
                            else stage = S_QNAME;
                        end
                    end
                    S_QNAME: take_name(b, 1'b0);
                    S_QLABEL:
                    begin
                        skip_cnt = skip_cnt - 16'd1;
                        if (skip_cnt == 16'd0) stage = S_QNAME;
                    end
                    S_QPTR:
                    begin
                        field_cnt = '0;
                        stage     = S_QFIXED;
                    end
                    S_QFIXED:
                    begin
                        field_cnt = field_cnt + 4'd1;
                        if (field_cnt >= QFIXED_LEN)
                        begin
                            field_cnt = '0;
                            qd_left   = qd_left - 16'd1;
                            stage     = (qd_left == 16'd0) ? S_ANAME : S_QNAME;
                        end
                    end
                    S_ANAME: take_name(b, 1'b1);
                    S_ALABEL:
                    begin
                        skip_cnt = skip_cnt - 16'd1;
                        if (skip_cnt == 16'd0) stage = S_ANAME;
                    end
                    S_APTR:
                    begin
                        field_cnt = '0;
                        stage     = S_AFIXED;
                    end
                    S_AFIXED:
                    begin
                        if (field_cnt == AF_TYPE_HI) rr_type = {b, 8'h00};
                        else if (field_cnt == AF_TYPE_LO) rr_type[7:0] = b;
                        else if (field_cnt == AF_LEN_HI) rr_len = {b, 8'h00};
                        else if (field_cnt == AF_LEN_LO) rr_len[7:0] = b;
                        field_cnt = field_cnt + 4'd1;
                        if (field_cnt >= AFIXED_LEN)
                        begin
                            field_cnt = '0;
                            if (rr_type == TYPE_A && rr_len == TYPE_A_LEN)
                            begin
                                addr_acc = '0;
                                stage    = S_AADDR;
                            end
                            else if (rr_len == 16'd0)
                            begin
                                close_answer();
                            end
                            else
                            begin
                                skip_cnt = rr_len;
                                stage    = S_ADATA;
                            end
                        end
                    end
                    S_ADATA:
                    begin
                        skip_cnt = skip_cnt - 16'd1;
                        if (skip_cnt == 16'd0) close_answer();
                    end
                    S_AADDR:
                    begin
                        addr_acc  = {addr_acc[23:0], b};
                        field_cnt = field_cnt + 4'd1;
                        if (field_cnt >= ADDR_LEN)
                        begin
                            field_cnt = '0;
                            found     = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (found)
        begin
            got         = 1'b1;
            ans.status  = ST_FOUND;
            ans.address = addr_acc;
            reported    = 1'b1;
            stage       = S_DONE;
        end

        // Last byte: fail status unless an address was already delivered
        if (last)
        begin
            if (!reported)
            begin
                got         = 1'b1;
                ans.address = '0;
                if (stage == S_HEADER || stage == S_BADHDR || byte_pos <= HDR_LEN)
                    ans.status = ST_BAD_HEADER;
                else
                    ans.status = ST_NO_RECORD;
            end
            clear_parser();
        end
    endtask

    // Drive one word into the block, then update the model on acceptance
    task automatic feed_byte(input logic [7:0] b, input logic last,
                             input bit pinned, input answer_t pin);
        int      gap;
        bit      got;
        answer_t ans;

        if (!burst_on && $urandom_range(0, 49) == 0) src_quiet = !src_quiet;
        gap = (burst_on || src_quiet) ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_if.valid     <= 1'b1;
        msg_if.data_byte <= b;
        msg_if.last_byte <= last;
        do @(posedge clk); while (!msg_if.ready);

        predict_byte(b, last, got, ans);
        if (pinned)
        begin
            if (!got || ans != pin)
            begin
                $display("%0t: model disagrees with table: expected %0d/%h, actual %0d/%h",
                         $time, pin.status, pin.address, ans.status, ans.address);
                mismatches++;
            end
            pending_answers.push_back(pin);
        end
        else if (got)
        begin
            pending_answers.push_back(ans);
        end
    endtask

    // Hold input and wait until every expected word has come back
    task automatic wait_drained();
        msg_if.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_random(input int n);
        repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Name as labels, ending in a root byte or a pointer; or a bare pointer
    task automatic add_name();
        int len;

        if ($urandom_range(0, 9) < 3)
        begin
            msg_bytes.push_back({2'b11, 6'($urandom_range(0, 63))});
            push_random(1);
        end
        else
        begin
            repeat ($urandom_range(0, 3))
            begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(64, 191)
                                                   : $urandom_range(1, 12);
                msg_bytes.push_back(8'(len));
                push_random(len);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                msg_bytes.push_back({2'b11, 6'($urandom_range(0, 63))});
                push_random(1);
            end
            else
            begin
                msg_bytes.push_back(8'h00);
            end
        end
    endtask

    task automatic build_message();
        int          kind;
        int          qd_cnt;
        int          an_cnt;
        int          cut;
        logic [15:0] rtype;
        logic [15:0] rlen;

        msg_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            push_random($urandom_range(1, 20));
        end
        else
        begin
            qd_cnt = $urandom_range(0, 2);
            an_cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            push_random(3);
            msg_bytes.push_back({4'($urandom_range(0, 15)),
                                 ($urandom_range(0, 7) == 0) ? 4'($urandom_range(1, 15))
                                                             : 4'd0});
            msg_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255))
                                                             : 8'h00);
            msg_bytes.push_back(8'(qd_cnt));
            msg_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255))
                                                             : 8'h00);
            msg_bytes.push_back(8'(an_cnt));
            push_random(4);

            repeat (qd_cnt)
            begin
                add_name();
                push_random(4);
            end

            // Answers: about half A records, the rest other types, and some odd lengths
            repeat (an_cnt)
            begin
                add_name();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: rtype = TYPE_A;
                    5, 6:          rtype = 16'd28;
                    7:             rtype = 16'd5;
                    default:       rtype = 16'($urandom_range(0, 65535));
                endcase
                rlen = (rtype == TYPE_A && $urandom_range(0, 4) != 0)
                       ? TYPE_A_LEN : 16'($urandom_range(0, 12));
                msg_bytes.push_back(rtype[15:8]);
                msg_bytes.push_back(rtype[7:0]);
                push_random(6);
                msg_bytes.push_back(rlen[15:8]);
                msg_bytes.push_back(rlen[7:0]);
                push_random(rlen);
            end

            // Reshape: truncate, add trailing junk, or pad out to near or past the byte limit
            if (kind < 25)
            begin
                cut = $urandom_range(1, msg_bytes.size());
                msg_bytes = msg_bytes[0:cut-1];
            end
            else if (kind < 45)
            begin
                push_random($urandom_range(1, 6));
            end
            else if (kind < 48)
            begin
                cut = $urandom_range(MAX_BYTES - 1, MAX_BYTES + 40);
                while (msg_bytes.size() < cut) push_random(1);
            end
        end
    endtask

    task automatic send_message();
        foreach (msg_bytes[i])
            feed_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, '0);
    endtask

    // Stimulus
    initial
    begin
        int byte_cnt;
        int msg_cnt;

        msg_if.valid     <= 1'b0;
        msg_if.data_byte <= 8'h00;
        msg_if.last_byte <= 1'b0;
        clear_parser();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            feed_byte(dir_tbl[i].data, dir_tbl[i].last, dir_tbl[i].pinned,
                      answer_t'{dir_tbl[i].status, dir_tbl[i].address});

        byte_cnt = 0;
        msg_cnt  = 0;
        while (byte_cnt < RANDOM_BYTES || msg_cnt < MIN_MESSAGES)
        begin
            if (msg_cnt == PAUSE_MSG) wait_drained();
            if (msg_cnt >= BURST_FIRST && msg_cnt < BURST_END)
            begin
                // Short back-to-back messages while the result side holds off
                hold_req = 1'b1;
                burst_on = 1'b1;
                msg_bytes.delete();
                push_random($urandom_range(1, 2));
            end
            else
            begin
                burst_on = 1'b0;
                build_message();
            end
            send_message();
            byte_cnt += msg_bytes.size();
            msg_cnt++;
        end

        wait_drained();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Result side ready: random stalls, one long hold-off
    initial
    begin
        int stall;

        res_if.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 49) == 0) snk_quiet = !snk_quiet;
            stall = snk_quiet ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
        end
    end

    // Compare each delivered word with the oldest expected one
    always @(posedge clk)
    begin
        answer_t want;

        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual status=%0d address=%h",
                         $time, res_if.status, res_if.address);
                mismatches++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (res_if.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, res_if.status);
                    mismatches++;
                end
                if (res_if.address !== want.address)
                begin
                    $display("%0t: address mismatch: expected %h, actual %h",
                             $time, want.address, res_if.address);
                    mismatches++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
